@@ rtl/sample_slot_allocator_unit_assert.svh @@
// Assertion macros for the sample slot allocator.
// Used by the top level and the divider; no other dependencies.
`ifndef SAMPLE_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define SAMPLE_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define SSA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/ssa_pkg.sv @@
// Package for the sample slot allocator: codes, sizes and small helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ssa_pkg;
    localparam int SLOTS         = 128;
    localparam int SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W         = $clog2(SLOTS + 1);
    localparam logic [31:0] ADDRESS_LIMIT = 32'd522240;
    localparam logic [31:0] BASE_RATE     = 32'd44100;
    localparam logic [18:0] INIT_ADDR     = 19'd1064;

    localparam logic [1:0] KIND_PCM16 = 2'd0;
    localparam logic [1:0] KIND_PCM8  = 2'd1;
    localparam logic [1:0] KIND_ADX   = 2'd2;
    localparam logic [1:0] KIND_TRIM  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ADDR      = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_BAD_HDR   = 3'd3;
    localparam logic [2:0] ST_BAD_RATE  = 3'd4;

    localparam logic [1:0] REG_IS_PAL = 2'd0;
    localparam logic [1:0] REG_INIT   = 2'd1;

    // divider request and result
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

    function automatic logic [14:0] dsz_of(input logic [31:0] bpb);
        logic [14:0] d;
        case (bpb)
            32'd768: d = 15'd19968;
            32'd512: d = 15'd9216;
            32'd384: d = 15'd5376;
            32'd256: d = 15'd2560;
            32'd192: d = 15'd5376;
            32'd128: d = 15'd5376;
            default: d = 15'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] bitlen(input logic [31:0] q);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (q[i]) n = 5'(i + 1);
        end
        return n;
    endfunction
endpackage
`default_nettype wire

@@ rtl/sample_slot_allocator_unit.sv @@
// Sample slot allocator: bump allocator over sound memory with a slot table.
// Depends on ssa_pkg and ssa_divider.
//
// Use: a request enters on the i_* payload with i_valid/o_ready; one result
// leaves on the o_* payload with o_valid/i_ready. Registers is_pal (0x0) and
// initial_load_address (0x4) sit on the APB port; writing the address also
// resets the load pointer and slot count.
// Sequence: a load runs three divisions in turn on one shared serial divider
// (frame bytes, 44100/(rate+1), then FNS); the FNS division is skipped when
// the low-rate rule makes FNS zero. A bad byte rate answers after the first
// division, a refused load or an out-of-range trim straight from the check
// state, and a trim after a read of the slot table.
// Flow: one request is worked on at a time; o_ready is high only when idle
// and the result register is empty, so a new request is taken only after the
// last result has left.
// Reset: load pointer becomes 1064, slot count 0; slot table contents are
// undefined until written. If the receiver stalls, the result stays in the
// output register and no new request is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "sample_slot_allocator_unit_assert.svh"
module sample_slot_allocator_unit import ssa_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [18:0] i_byte_size,
    input  wire logic [14:0] i_sample_rate,
    input  wire logic [15:0] i_hdr_one_half,
    input  wire logic [7:0]  i_hdr_block_size,
    input  wire logic [7:0]  i_hdr_bit_depth,
    input  wire logic [15:0] i_hdr_data_offset,
    input  wire logic [14:0] i_hdr_sample_rate,
    input  wire logic [31:0] i_hdr_sample_count,
    input  wire logic [7:0]  i_keep_index,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [7:0]       o_slot_index,
    output logic [31:0]      o_start_address,
    output logic [14:0]      o_pitch_word,
    output logic [31:0]      o_play_size,
    output logic [14:0]      o_frame_bytes,
    output logic [14:0]      o_decompress_size,
    output logic [1:0]       o_sample_type
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_BPB   = 8'b0000_0100,
        S_QDIV  = 8'b0000_1000,
        S_FNS   = 8'b0001_0000,
        S_TRIM  = 8'b0010_0000,
        S_TRIM2 = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic        r_is_pal;
    logic [18:0] r_init;
    logic [31:0] r_lp;
    logic [CNT_W-1:0] r_cnt;

    // request latch
    logic [1:0]  r_kind;
    logic [18:0] r_size;
    logic [14:0] r_rate;
    logic        r_hdr_ok;
    logic [15:0] r_offs;
    logic [31:0] r_count;
    logic [7:0]  r_keep;
    logic        r_dstarted;

    // slot table
    logic [31:0] mem_addr [SLOTS];
    logic [31:0] mem_ps   [SLOTS];
    logic [1:0]  mem_type [SLOTS];
    logic [31:0] r_rd_addr, r_rd_ps;
    logic [1:0]  r_rd_type;

    logic [31:0] r_bpb;
    logic [4:0]  r_oct;
    logic [31:0] r_shift;

    // result register
    logic        r_ovalid;
    logic [2:0]  r_status;
    logic [7:0]  r_slot;
    logic [31:0] r_start, r_play;
    logic [14:0] r_pitch, r_obpb, r_dsz;
    logic [1:0]  r_type;

    t_div_req div_req;
    t_div_rsp div_rsp;

    ssa_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    wire cfg_wr = psel && penable && pwrite;
    wire accept = i_valid && o_ready;
    assign pready  = 1'b1;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        case (paddr[2])
            1'b0:    prdata = {31'd0, r_is_pal};
            default: prdata = {13'd0, r_init};
        endcase
    end

    wire [14:0] eff_rate  = (r_kind == KIND_ADX) ? r_rate : r_rate;
    wire [31:0] frames    = {5'd0, r_count[31:5]};
    wire [31:0] frames18  = (frames << 4) + (frames << 1);
    wire [31:0] rs        = ({13'd0, r_size} + 32'd3) & ~32'd3;
    wire [31:0] adx_adv   = (frames18 + 32'd3) & ~32'd3;
    wire [14:0] dsz       = dsz_of(r_bpb);
    wire [31:0] bpb_num   = (r_kind == KIND_PCM8) ? {17'd0, eff_rate}
                                                  : {16'd0, eff_rate, 1'b0};
    wire [4:0]  oct_raw   = bitlen(div_rsp.quot);
    wire [4:0]  oct_sat   = (oct_raw > 5'd15) ? 5'd15 : oct_raw;
    wire [31:0] shift_v   = BASE_RATE >> oct_sat;
    wire        fns_ok    = {17'd0, r_rate} >= r_shift;
    wire [31:0] fns_num   = ({17'd0, r_rate} - r_shift) << 10;
    wire [SLOT_W-1:0] wr_idx = r_cnt[SLOT_W-1:0];
    wire [31:0] trim_p = (r_rd_type == KIND_ADX) ?
                             r_rd_addr + (r_rd_ps << 4) + (r_rd_ps << 1) :
                         (r_rd_type == KIND_PCM8) ? r_rd_addr + r_rd_ps :
                         (r_rd_type == KIND_PCM16) ? r_rd_addr + (r_rd_ps << 1) :
                         r_rd_addr;

    always_comb begin
        n_state = r_state;
        div_req = '0;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_CHECK;
            S_CHECK: begin
                if (r_kind == KIND_TRIM) begin
                    n_state = ({24'd0, r_keep} >= 32'(SLOTS)) ? S_DONE : S_TRIM;
                end else if (r_lp > ADDRESS_LIMIT || 32'(r_cnt) >= 32'(SLOTS)
                             || (r_kind == KIND_ADX && !r_hdr_ok)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_BPB;
                end
            end
            S_BPB: begin
                div_req.start    = !r_dstarted;
                div_req.dividend = bpb_num;
                div_req.divisor  = r_is_pal ? 32'd50 : 32'd60;
                if (div_rsp.done) begin
                    n_state = (r_kind == KIND_ADX && dsz_of(div_rsp.quot) == 15'd0)
                              ? S_DONE : S_QDIV;
                end
            end
            S_QDIV: begin
                div_req.start    = !r_dstarted;
                div_req.dividend = BASE_RATE;
                div_req.divisor  = {17'd0, r_rate} + 32'd1;
                if (div_rsp.done) n_state = S_FNS;
            end
            S_FNS: begin
                div_req.start    = !r_dstarted && fns_ok;
                div_req.dividend = fns_num;
                div_req.divisor  = r_shift;
                if (!fns_ok || div_rsp.done) n_state = S_DONE;
            end
            S_TRIM:  n_state = S_TRIM2;
            S_TRIM2: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_size  <= i_byte_size;
            r_rate  <= (i_kind == KIND_ADX) ? i_hdr_sample_rate : i_sample_rate;
            r_hdr_ok <= i_hdr_one_half == 16'd32768 && i_hdr_block_size == 8'd18
                        && i_hdr_bit_depth == 8'd4;
            r_offs  <= i_hdr_data_offset;
            r_count <= i_hdr_sample_count;
            r_keep  <= i_keep_index;
        end
        if (r_state == S_TRIM) begin
            r_rd_addr <= mem_addr[r_keep[SLOT_W-1:0]];
            r_rd_ps   <= mem_ps[r_keep[SLOT_W-1:0]];
            r_rd_type <= mem_type[r_keep[SLOT_W-1:0]];
        end
        if (r_state == S_BPB && div_rsp.done) r_bpb <= div_rsp.quot;
        if (r_state == S_QDIV && div_rsp.done) begin
            r_oct   <= oct_sat;
            r_shift <= shift_v;
        end
        if (r_state == S_FNS && n_state == S_DONE && r_kind != KIND_TRIM) begin
            if (r_kind == KIND_ADX) begin
                mem_addr[wr_idx] <= r_lp + {16'd0, r_offs} + 32'd4;
                mem_ps[wr_idx]   <= frames;
            end else begin
                mem_addr[wr_idx] <= r_lp;
                mem_ps[wr_idx]   <= (r_kind == KIND_PCM16) ? (rs >> 1) : rs;
            end
            mem_type[wr_idx] <= r_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_is_pal   <= 1'b0;
            r_init     <= INIT_ADDR;
            r_lp       <= {13'd0, INIT_ADDR};
            r_cnt      <= '0;
            r_ovalid   <= 1'b0;
            r_dstarted <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) r_dstarted <= 1'b0;
            else if (div_req.start) r_dstarted <= 1'b1;
            if (cfg_wr) begin
                unique case (paddr[2:2])
                    REG_IS_PAL[0:0]: r_is_pal <= pwdata[0];
                    default: begin
                        r_init <= pwdata[18:0];
                        r_lp   <= {13'd0, pwdata[18:0]};
                        r_cnt  <= '0;
                    end
                endcase
            end
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (r_state == S_CHECK && n_state == S_DONE) begin
                r_ovalid <= 1'b1;
                r_slot <= 8'd0; r_start <= 32'd0; r_pitch <= 15'd0;
                r_play <= 32'd0; r_obpb <= 15'd0; r_dsz <= 15'd0; r_type <= 2'd0;
                if (r_kind == KIND_TRIM || 32'(r_cnt) >= 32'(SLOTS)
                    && !(r_lp > ADDRESS_LIMIT))
                    r_status <= ST_FULL;
                else if (r_lp > ADDRESS_LIMIT) r_status <= ST_ADDR;
                else r_status <= ST_BAD_HDR;
            end
            if (r_state == S_BPB && n_state == S_DONE) begin
                r_ovalid <= 1'b1;
                r_status <= ST_BAD_RATE;
                r_slot <= 8'd0; r_start <= 32'd0; r_pitch <= 15'd0;
                r_play <= 32'd0; r_obpb <= 15'd0; r_dsz <= 15'd0; r_type <= 2'd0;
            end
            if (r_state == S_TRIM2) begin
                r_ovalid <= 1'b1;
                r_status <= ST_OK;
                r_slot <= r_keep; r_start <= trim_p; r_pitch <= 15'd0;
                r_play <= 32'd0; r_obpb <= 15'd0; r_dsz <= 15'd0; r_type <= 2'd0;
                r_lp  <= trim_p;
                r_cnt <= CNT_W'({1'b0, r_keep} + 9'd1);
            end
            if (r_state == S_FNS && n_state == S_DONE) begin
                r_ovalid <= 1'b1;
                r_status <= ST_OK;
                r_slot   <= 8'(r_cnt);
                r_pitch  <= {4'(5'd0 - r_oct), 1'b0,
                             fns_ok ? div_rsp.quot[9:0] : 10'd0};
                r_obpb   <= r_bpb[14:0];
                r_type   <= r_kind;
                r_cnt    <= r_cnt + CNT_W'(1);
                if (r_kind == KIND_ADX) begin
                    r_start <= r_lp + {16'd0, r_offs} + 32'd4;
                    r_play  <= frames;
                    r_dsz   <= dsz;
                    r_lp    <= r_lp + adx_adv;
                end else begin
                    r_start <= r_lp;
                    r_play  <= (r_kind == KIND_PCM16) ? (rs >> 1) : rs;
                    r_dsz   <= 15'd0;
                    r_lp    <= r_lp + rs;
                end
            end
        end
    end

    assign o_valid           = r_ovalid;
    assign o_status          = r_status;
    assign o_slot_index      = r_slot;
    assign o_start_address   = r_start;
    assign o_pitch_word      = r_pitch;
    assign o_play_size       = r_play;
    assign o_frame_bytes     = r_obpb;
    assign o_decompress_size = r_dsz;
    assign o_sample_type     = r_type;

    `SSA_ASSERT(a_ready_idle, i_clk, i_rst_n, !o_ready || (r_state == S_IDLE && !r_ovalid))
    `SSA_ASSERT(a_cnt_bound, i_clk, i_rst_n, 32'(r_cnt) <= 32'(SLOTS))
    `SSA_ASSERT(a_done_valid, i_clk, i_rst_n, r_state != S_DONE || r_ovalid)
endmodule
`default_nettype wire

@@ rtl/ssa_divider.sv @@
// Shared restoring divider, one quotient bit per cycle: it iterates once per quotient bit after the
// start cycle, with done raised on the cycle after the last one. Depends on ssa_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "sample_slot_allocator_unit_assert.svh"
module ssa_divider import ssa_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] trial;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[31]} - {1'b0, r_den};
        if (i_req.start && !r_busy) begin
            n_rem  = 32'd0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[32]) begin
                n_rem = trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_quo[31]};
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

    `SSA_ASSERT(a_done_not_busy, i_clk, i_rst_n, !(r_done && r_busy))
    `SSA_ASSERT_NEXT(a_done_after_last, i_clk, i_rst_n, r_busy && r_cnt == 6'd31, r_done)
    `SSA_ASSERT(a_cnt_range, i_clk, i_rst_n, r_busy || r_cnt == 6'd0 || r_cnt == 6'd32)
endmodule
`default_nettype wire

@@ sim/sample_slot_allocator_unit_checker.sv @@
// Scoreboard for the sample slot allocator: predicts every result and compares it.
// It watches the APB writes and the request and result channels. Depends on ssa_pkg.
`timescale 1ns / 1ps
module sample_slot_allocator_unit_checker import ssa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    input  logic                i_valid,
    input  logic                o_ready,
    input  logic [1:0]          i_kind,
    input  logic [18:0]         i_byte_size,
    input  logic [14:0]         i_sample_rate,
    input  logic [15:0]         i_hdr_one_half,
    input  logic [7:0]          i_hdr_block_size,
    input  logic [7:0]          i_hdr_bit_depth,
    input  logic [15:0]         i_hdr_data_offset,
    input  logic [14:0]         i_hdr_sample_rate,
    input  logic [31:0]         i_hdr_sample_count,
    input  logic [7:0]          i_keep_index,
    input  logic                o_valid,
    input  logic                i_ready,
    input  logic [2:0]          o_status,
    input  logic [7:0]          o_slot_index,
    input  logic [31:0]         o_start_address,
    input  logic [14:0]         o_pitch_word,
    input  logic [31:0]         o_play_size,
    input  logic [14:0]         o_frame_bytes,
    input  logic [14:0]         o_decompress_size,
    input  logic [1:0]          o_sample_type,
    output int                  fail_count,
    output int                  results_pending,
    output logic [SLOTS-1:0]    slot_loaded
);
    typedef struct {
        logic [2:0]  status;
        logic [7:0]  slot_index;
        logic [31:0] start_address;
        logic [14:0] pitch_word;
        logic [31:0] play_size;
        logic [14:0] frame_bytes;
        logic [14:0] decompress_size;
        logic [1:0]  sample_type;
    } t_alloc_result;

    logic        pal_mode;
    logic [31:0] load_ptr;
    logic [8:0]  used_slots;
    logic [31:0] tbl_addr [SLOTS];
    logic [31:0] tbl_size [SLOTS];
    logic [1:0]  tbl_type [SLOTS];
    t_alloc_result expected_results [$];

    function automatic logic [14:0] pitch_of(input logic [31:0] rate);
        logic [31:0] q, shift, fns, oct;
        q = BASE_RATE / (rate + 1);
        oct = 0;
        while (q != 0) begin
            oct++;
            q = q >> 1;
        end
        if (oct > 15) oct = 15;
        shift = BASE_RATE >> oct;
        fns = (rate >= shift) ? ((rate - shift) << 10) / shift : 32'd0;
        return 15'({((32'd0 - oct) & 32'hF), 1'b0, fns[9:0]});
    endfunction

    function automatic logic [31:0] blank_bytes(input logic [31:0] rate, input logic eight);
        return ((rate * (eight ? 32'd8 : 32'd16)) >> 3) / (pal_mode ? 32'd50 : 32'd60);
    endfunction

    function automatic logic [31:0] adx_buffer(input logic [31:0] bpb);
        case (bpb)
            32'd768: return 32'd19968;
            32'd512: return 32'd9216;
            32'd256: return 32'd2560;
            32'd384, 32'd192, 32'd128: return 32'd5376;
            default: return 32'd0;
        endcase
    endfunction

    // advances the allocator copy by the request on the input ports
    function automatic t_alloc_result allocate_request();
        t_alloc_result r;
        logic [31:0] p, bpb, dsz, frames, rs;
        int k;
        r = '{default: '0};
        k = used_slots;
        if (i_kind == KIND_TRIM) begin
            if (i_keep_index >= SLOTS) begin
                r.status = ST_FULL;
            end else begin
                p = tbl_addr[i_keep_index];
                case (tbl_type[i_keep_index])
                    KIND_ADX:   p = p + tbl_size[i_keep_index] * 18;
                    KIND_PCM8:  p = p + tbl_size[i_keep_index];
                    KIND_PCM16: p = p + (tbl_size[i_keep_index] << 1);
                    default: ;
                endcase
                load_ptr = p;
                used_slots = i_keep_index + 1;
                r.slot_index = i_keep_index;
                r.start_address = p;
            end
        end else if (load_ptr > ADDRESS_LIMIT) begin
            r.status = ST_ADDR;
        end else if (used_slots >= SLOTS) begin
            r.status = ST_FULL;
        end else if (i_kind == KIND_ADX) begin
            bpb = blank_bytes(i_hdr_sample_rate, 1'b0);
            dsz = adx_buffer(bpb);
            if (i_hdr_one_half != 16'd32768 || i_hdr_block_size != 8'd18
                    || i_hdr_bit_depth != 8'd4) begin
                r.status = ST_BAD_HDR;
            end else if (dsz == 0) begin
                r.status = ST_BAD_RATE;
            end else begin
                frames = i_hdr_sample_count / 32;
                p = load_ptr + i_hdr_data_offset + 4;
                tbl_addr[k] = p;
                tbl_size[k] = frames;
                tbl_type[k] = KIND_ADX;
                slot_loaded[k] = 1'b1;
                used_slots = k + 1;
                load_ptr = load_ptr + ((frames * 18 + 3) & ~32'd3);
                r.slot_index = k;
                r.start_address = p;
                r.pitch_word = pitch_of(i_hdr_sample_rate);
                r.play_size = frames;
                r.frame_bytes = bpb[14:0];
                r.decompress_size = dsz[14:0];
                r.sample_type = KIND_ADX;
            end
        end else begin
            rs = (32'(i_byte_size) + 3) & ~32'd3;
            tbl_addr[k] = load_ptr;
            tbl_size[k] = (i_kind == KIND_PCM16) ? rs >> 1 : rs;
            tbl_type[k] = i_kind;
            slot_loaded[k] = 1'b1;
            used_slots = k + 1;
            r.slot_index = k;
            r.start_address = load_ptr;
            r.pitch_word = pitch_of(i_sample_rate);
            r.play_size = tbl_size[k];
            bpb = blank_bytes(i_sample_rate, i_kind == KIND_PCM8);
            r.frame_bytes = bpb[14:0];
            r.sample_type = i_kind;
            load_ptr = load_ptr + rs;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_alloc_result e;
        if (!i_rst_n) begin
            pal_mode = 1'b0;
            load_ptr = 32'(INIT_ADDR);
            used_slots = '0;
            slot_loaded = '0;
            fail_count = 0;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == 3'({REG_IS_PAL, 2'b00})) begin
                    pal_mode = pwdata[0];
                end else if (paddr == 3'({REG_INIT, 2'b00})) begin
                    load_ptr = {13'd0, pwdata[18:0]};
                    used_slots = '0;
                end
            end
            // result leaves before the next request can enter
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("status", e.status, o_status);
                    check_field("slot_index", e.slot_index, o_slot_index);
                    check_field("start_address", e.start_address, o_start_address);
                    check_field("pitch_word", e.pitch_word, o_pitch_word);
                    check_field("play_size", e.play_size, o_play_size);
                    check_field("frame_bytes", e.frame_bytes, o_frame_bytes);
                    check_field("decompress_size", e.decompress_size, o_decompress_size);
                    check_field("sample_type", e.sample_type, o_sample_type);
                end
            end
            if (i_valid && o_ready) expected_results.push_back(allocate_request());
        end
        results_pending = expected_results.size();
    end
endmodule

@@ sim/sample_slot_allocator_unit_tb.sv @@
// Testbench top for the sample slot allocator: clock, reset, APB writes and requests.
// Depends on ssa_pkg, the block and sample_slot_allocator_unit_checker.
`timescale 1ns / 1ps
module sample_slot_allocator_unit_tb import ssa_pkg::*;;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0, o_ready;
    logic [1:0] i_kind = '0;
    logic [18:0] i_byte_size = '0;
    logic [14:0] i_sample_rate = '0;
    logic [15:0] i_hdr_one_half = '0;
    logic [7:0] i_hdr_block_size = '0, i_hdr_bit_depth = '0;
    logic [15:0] i_hdr_data_offset = '0;
    logic [14:0] i_hdr_sample_rate = '0;
    logic [31:0] i_hdr_sample_count = '0;
    logic [7:0] i_keep_index = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [2:0] o_status;
    logic [7:0] o_slot_index;
    logic [31:0] o_start_address, o_play_size;
    logic [14:0] o_pitch_word, o_frame_bytes, o_decompress_size;
    logic [1:0] o_sample_type;

    int fail_count, results_pending;
    logic [SLOTS-1:0] slot_loaded;
    int requests_sent = 0;
    int idle_cycles = 0;
    logic pal_setting = 1'b0;
    logic tx_idle_on = 1'b0, rx_idle_on = 1'b0;
    int rx_hold = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sample_slot_allocator_unit dut (.*);
    sample_slot_allocator_unit_checker scoreboard (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 12);
        return $urandom_range(30, 200);
    endfunction

    always @(negedge i_clk) begin
        if (!rx_idle_on) begin
            i_ready = 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            i_ready = $urandom_range(0, 2) != 0;
            rx_hold = gap_len();
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("sample_slot_allocator_unit test failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (results_pending != 0 || i_valid) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
        wait_drained();
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = 3'({index, 2'b00}); pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (index == REG_IS_PAL) pal_setting = value[0];
    endtask

    task automatic scramble_fields();
        i_byte_size = 19'($urandom);
        i_sample_rate = 15'($urandom);
        i_hdr_one_half = 16'($urandom);
        i_hdr_block_size = 8'($urandom);
        i_hdr_bit_depth = 8'($urandom);
        i_hdr_data_offset = 16'($urandom);
        i_hdr_sample_rate = 15'($urandom);
        i_hdr_sample_count = $urandom;
        i_keep_index = 8'($urandom);
    endtask

    // valid ADX header whose byte rate lands on the given bytes per frame
    task automatic set_adx_header(input int bpb);
        int frames;
        frames = pal_setting ? 50 : 60;
        i_hdr_one_half = 16'd32768;
        i_hdr_block_size = 8'd18;
        i_hdr_bit_depth = 8'd4;
        i_hdr_sample_rate = 15'(bpb * frames / 2 + $urandom_range(0, frames / 2 - 1));
    endtask

    // payload is set by the caller at a falling edge; holds until accepted
    task automatic issue_request(input logic [1:0] kind);
        i_kind = kind;
        i_valid = 1'b1;
        #1;
        while (!o_ready) begin
            @(negedge i_clk);
            #1;
        end
        @(posedge i_clk);
        requests_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
        if (tx_idle_on) repeat (gap_len()) @(negedge i_clk);
    endtask

    task automatic trim_to_loaded();
        int k;
        wait_drained();
        scramble_fields();
        k = -1;
        repeat (16) begin
            i_keep_index = 8'($urandom_range(0, SLOTS - 1));
            if (slot_loaded[i_keep_index]) k = i_keep_index;
        end
        if (k >= 0) i_keep_index = 8'(k);
        else i_keep_index = 8'($urandom_range(SLOTS, 255));
        issue_request(KIND_TRIM);
    endtask

    task automatic random_request();
        int r;
        int rates [6] = '{768, 512, 384, 256, 192, 128};
        r = $urandom_range(0, 99);
        scramble_fields();
        if ($urandom_range(0, 9) != 0) i_byte_size = 19'($urandom_range(0, 4095));
        if ($urandom_range(0, 9) != 0) i_hdr_sample_count = $urandom_range(0, 65535);
        if (r < 12) begin
            trim_to_loaded();
        end else if (r < 15) begin
            i_keep_index = 8'($urandom_range(SLOTS, 255));
            issue_request(KIND_TRIM);
        end else if (r < 45) begin
            if ($urandom_range(0, 9) < 8) set_adx_header(rates[$urandom_range(0, 5)]);
            else if ($urandom_range(0, 1)) i_hdr_one_half = 16'd32768;
            issue_request(KIND_ADX);
        end else if (r < 47) begin
            issue_request(KIND_TRIM == 2'd3 ? 2'($urandom_range(0, 2)) : KIND_PCM8);
        end else begin
            issue_request($urandom_range(0, 1) ? KIND_PCM16 : KIND_PCM8);
        end
    endtask

    initial begin
        int rates [6] = '{768, 512, 384, 256, 192, 128};
        int settings [6] = '{0, 524287, 1064, 4, 520000, 2000};
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: reset configuration, field extremes, every kind
        scramble_fields();
        i_byte_size = '0; i_sample_rate = '0;
        issue_request(KIND_PCM16);
        i_byte_size = 19'd1; i_sample_rate = 15'd1;
        issue_request(KIND_PCM8);
        i_byte_size = 19'd6; i_sample_rate = 15'h7FFF;
        issue_request(KIND_PCM16);
        foreach (rates[i]) begin
            scramble_fields();
            i_hdr_sample_count = $urandom_range(0, 4096);
            set_adx_header(rates[i]);
            if (i == 0) i_hdr_data_offset = 16'hFFFF;
            if (i == 1) i_hdr_sample_count = '0;
            issue_request(KIND_ADX);
        end
        set_adx_header(768); i_hdr_one_half = 16'd32767;
        issue_request(KIND_ADX);
        set_adx_header(768); i_hdr_block_size = 8'd19;
        issue_request(KIND_ADX);
        set_adx_header(768); i_hdr_bit_depth = 8'd8;
        issue_request(KIND_ADX);
        set_adx_header(100);
        issue_request(KIND_ADX);
        i_keep_index = 8'd0;
        issue_request(KIND_TRIM);
        i_keep_index = 8'd200;
        issue_request(KIND_TRIM);
        i_keep_index = 8'hFF;
        issue_request(KIND_TRIM);
        i_byte_size = 19'h7FFFF; i_sample_rate = 15'd22050;
        issue_request(KIND_PCM8);
        // pointer now past the limit
        issue_request(KIND_PCM16);
        set_adx_header(512);
        issue_request(KIND_ADX);
        i_keep_index = 8'd2;
        issue_request(KIND_TRIM);

        // fill the table with tiny loads until it reports full
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        reg_write(REG_INIT, 32'd0);
        repeat (SLOTS + 3) begin
            scramble_fields();
            i_byte_size = 19'($urandom_range(0, 64));
            issue_request(2'($urandom_range(0, 1)));
        end
        set_adx_header(256);
        issue_request(KIND_ADX);

        for (int phase = 0; phase < 8; phase++) begin
            reg_write(REG_IS_PAL, 32'(phase & 1) | ($urandom & 32'hFFFF_FFFE));
            reg_write(REG_INIT, (phase < 6) ? 32'(settings[phase]) | ($urandom & 32'hFFF8_0000)
                                            : $urandom);
            tx_idle_on = phase % 3 != 1;
            rx_idle_on = phase % 3 != 2;
            for (int n = 0; n < 130; n++) begin
                if (n == 65) wait_drained();
                random_request();
            end
        end

        wait_drained();
        repeat (200) @(negedge i_clk);
        $display("%0d requests sent over ten configuration phases: all kinds, refusals,", requests_sent);
        $display("table fill, trims to loaded slots and both video regions.");
        if (fail_count == 0 && results_pending == 0) begin
            $display("sample_slot_allocator_unit test passed");
        end else begin
            $display("sample_slot_allocator_unit test failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ssa_pkg.sv
rtl/ssa_divider.sv
rtl/sample_slot_allocator_unit.sv
sim/sample_slot_allocator_unit_checker.sv
sim/sample_slot_allocator_unit_tb.sv
